// ----- src/fcfs_waiting_time_scheduler_assert.svh -----
// assertion macros for the fcfs waiting-time scheduler
// used only by the top level; expects clk_i and rst_ni in scope
`ifndef FCFS_WAITING_TIME_SCHEDULER_ASSERT_SVH
`define FCFS_WAITING_TIME_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define FCFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/fcfs_pkg.sv -----
// shared types and constants of the fcfs waiting-time scheduler
// no dependencies
package fcfs_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int TAG_W     = 4;
  localparam int ARR_W     = 17;
  localparam int BURST_W   = 16;
  localparam int WAIT_W    = 20;
  localparam int TOTAL_W   = 24;

  // exit time is below 2^ARR_W + MAX_PROCS * 2^BURST_W
  localparam int EXIT_W    = BURST_W + IDX_W + 2;
  localparam int TOT_W     = EXIT_W + IDX_W;
  localparam int WSAT_W    = (EXIT_W > WAIT_W) ? EXIT_W : WAIT_W;
  localparam int TSAT_W    = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;

  // sort key: arrival then load position, which keeps equal arrivals stable
  localparam int KEY_W     = ARR_W + IDX_W;

  localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
  } rec_t;

  typedef struct packed {
    logic clear_best;  // start a new scan
    logic advance;     // chosen record becomes the new lower bound
    logic restart;     // new set, no lower bound
  } sel_ctrl_t;

endpackage

// ----- src/fcfs_rec_ram.sv -----
// process record store: one write port, one registered read port
// depends on fcfs_pkg
module fcfs_rec_ram import fcfs_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  rec_t             wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output rec_t             rdata_o
);

  rec_t mem_q [MAX_PROCS];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fcfs_sel_unit.sv -----
// shared compare unit: finds the smallest key above the last one served
// depends on fcfs_pkg
module fcfs_sel_unit import fcfs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sel_ctrl_t        ctrl_i,
  input  logic             cand_vld_i,
  input  logic [IDX_W-1:0] cand_idx_i,
  input  rec_t             cand_rec_i,
  output rec_t             best_rec_o
);

  logic             best_vld_q, best_vld_d;
  logic             lo_vld_q, lo_vld_d;
  logic [KEY_W-1:0] best_key_q, best_key_d;
  logic [KEY_W-1:0] lo_key_q, lo_key_d;
  rec_t             best_rec_q, best_rec_d;
  logic [KEY_W-1:0] cand_key;
  logic             above_lo, below_best, take;

  assign cand_key   = {cand_rec_i.arr, cand_idx_i};
  assign above_lo   = !lo_vld_q || (cand_key > lo_key_q);
  assign below_best = !best_vld_q || (cand_key < best_key_q);
  assign take       = cand_vld_i && above_lo && below_best;

  always_comb begin
    best_vld_d = best_vld_q;
    best_key_d = best_key_q;
    best_rec_d = best_rec_q;
    lo_vld_d   = lo_vld_q;
    lo_key_d   = lo_key_q;
    if (ctrl_i.clear_best) begin
      best_vld_d = 1'b0;
    end else if (take) begin
      best_vld_d = 1'b1;
      best_key_d = cand_key;
      best_rec_d = cand_rec_i;
    end
    if (ctrl_i.restart) begin
      lo_vld_d = 1'b0;
    end else if (ctrl_i.advance) begin
      lo_vld_d = 1'b1;
      lo_key_d = best_key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_vld_q <= 1'b0;
      lo_vld_q   <= 1'b0;
    end else begin
      best_vld_q <= best_vld_d;
      lo_vld_q   <= lo_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
    best_rec_q <= best_rec_d;
    lo_key_q   <= lo_key_d;
  end

  assign best_rec_o = best_rec_q;

endmodule

// ----- src/fcfs_waiting_time_scheduler.sv -----
// fcfs waiting-time scheduler top level: sequencer, wait arithmetic, output register
// depends on fcfs_pkg, fcfs_rec_ram, fcfs_sel_unit, fcfs_waiting_time_scheduler_assert.svh
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------------
//   in       | in_valid_i / in_ready_o   | proc_tag, arrival_time, burst_time, last_item
//   out      | out_valid_o / out_ready_i | out_tag, out_arrival, out_burst,
//            |                           | wait_time, total_wait, last_result
//
// a request that does not close the set is taken while the sequencer stays in load
// a closed set is served by a sequential scan of the record store for each service
// position, and output stalls hold it further
// no request is taken from the closing request until the last result is taken
// reset clears the fill count and the sequencer; the record store is not cleared
`include "fcfs_waiting_time_scheduler_assert.svh"

module fcfs_waiting_time_scheduler import fcfs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [TAG_W-1:0]   proc_tag_i,
  input  logic [ARR_W-1:0]   arrival_time_i,
  input  logic [BURST_W-1:0] burst_time_i,
  input  logic               last_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [TAG_W-1:0]   out_tag_o,
  output logic [ARR_W-1:0]   out_arrival_o,
  output logic [BURST_W-1:0] out_burst_o,
  output logic [WAIT_W-1:0]  wait_time_o,
  output logic [TOTAL_W-1:0] total_wait_o,
  output logic               last_result_o
);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_SCAN = 5'b00010,
    S_WAIT = 5'b00100,
    S_CALC = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q;
  logic [EXIT_W-1:0]  prev_exit_q, prev_exit_d;
  logic [EXIT_W-1:0]  wait_raw_q, wait_raw_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [WAIT_W-1:0]  wait_out_q, wait_out_d;
  logic [TOTAL_W-1:0] total_out_q, total_out_d;
  logic               last_q, last_d;

  logic               in_acc, room, we, issuing;
  sel_ctrl_t          sel_ctrl;
  rec_t               wr_rec, rd_rec, best_rec;
  logic [EXIT_W-1:0]  arr_ext, burst_ext, exit_base;
  logic [WSAT_W-1:0]  wait_ext;
  logic [TSAT_W-1:0]  total_ext;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign room        = (cnt_q < CNT_W'(MAX_PROCS));
  assign we          = in_acc && room;
  assign issuing     = (scan_q < cnt_q);

  assign wr_rec.tag   = proc_tag_i;
  assign wr_rec.arr   = arrival_time_i;
  assign wr_rec.burst = burst_time_i;

  fcfs_rec_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (wr_rec),
    .raddr_i (scan_q[IDX_W-1:0]),
    .rdata_o (rd_rec)
  );

  fcfs_sel_unit u_sel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sel_ctrl),
    .cand_vld_i (rd_vld_q),
    .cand_idx_i (rd_idx_q),
    .cand_rec_i (rd_rec),
    .best_rec_o (best_rec)
  );

  assign arr_ext   = EXIT_W'(best_rec.arr);
  assign burst_ext = EXIT_W'(best_rec.burst);
  // a nonzero wait means service starts at the previous exit
  assign exit_base = (wait_raw_q != '0) ? prev_exit_q : arr_ext;
  assign wait_ext  = WSAT_W'(wait_raw_q);
  assign total_ext = TSAT_W'(total_q + TOT_W'(wait_raw_q));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    prev_exit_d = prev_exit_q;
    wait_raw_d  = wait_raw_q;
    total_d     = total_q;
    wait_out_d  = wait_out_q;
    total_out_d = total_out_q;
    last_d      = last_q;
    sel_ctrl    = '0;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (last_item_i) begin
            pos_d              = '0;
            scan_d             = '0;
            total_d            = '0;
            sel_ctrl.clear_best = 1'b1;
            sel_ctrl.restart    = 1'b1;
            state_d            = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_vld_d = issuing;
        if (issuing) begin
          scan_d = scan_q + CNT_W'(1);
        end else if (!rd_vld_q) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if ((pos_q != '0) && (prev_exit_q > arr_ext)) begin
          wait_raw_d = prev_exit_q - arr_ext;
        end else begin
          wait_raw_d = '0;
        end
        state_d = S_CALC;
      end
      S_CALC: begin
        prev_exit_d      = exit_base + burst_ext;
        total_d          = total_q + TOT_W'(wait_raw_q);
        wait_out_d       = (wait_ext > WSAT_W'(WAIT_MAX)) ? WAIT_MAX
                                                          : wait_ext[WAIT_W-1:0];
        total_out_d      = (total_ext > TSAT_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                            : total_ext[TOTAL_W-1:0];
        last_d           = (pos_q == (cnt_q - CNT_W'(1)));
        sel_ctrl.advance = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          if (last_q) begin
            cnt_d   = '0;
            state_d = S_LOAD;
          end else begin
            pos_d               = pos_q + CNT_W'(1);
            scan_d              = '0;
            sel_ctrl.clear_best = 1'b1;
            state_d             = S_SCAN;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      cnt_q    <= '0;
      pos_q    <= '0;
      scan_q   <= '0;
      rd_vld_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= scan_q[IDX_W-1:0];
    prev_exit_q <= prev_exit_d;
    wait_raw_q  <= wait_raw_d;
    total_q     <= total_d;
    wait_out_q  <= wait_out_d;
    total_out_q <= total_out_d;
  end

  assign out_tag_o     = best_rec.tag;
  assign out_arrival_o = best_rec.arr;
  assign out_burst_o   = best_rec.burst;
  assign wait_time_o   = wait_out_q;
  assign total_wait_o  = total_out_q;
  assign last_result_o = last_q;

  `FCFS_ASSERT_NOW(a_no_overlap, out_valid_o, !in_ready_o, "input taken while a result is pending")
  `FCFS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CNT_W'(MAX_PROCS), "fill count beyond capacity")
  `FCFS_ASSERT_NOW(a_pos_range, out_valid_o, pos_q < cnt_q, "service position beyond set size")
  `FCFS_ASSERT_NEXT(a_back_to_load, out_valid_o && out_ready_i && last_result_o, in_ready_o && (cnt_q == '0), "no return to load after final result")

endmodule

// ----- dv/fcfs_waiting_time_scheduler_tb.sv -----
// self-checking testbench for the fcfs waiting-time scheduler
// directed sets then random sets, checked against typed results or an in-bench predictor
// depends on fcfs_pkg and the fcfs_waiting_time_scheduler rtl
`timescale 1ns / 1ps

module fcfs_waiting_time_scheduler_tb;
  import fcfs_pkg::*;

  localparam int ARR_TOP      = 90060;
  localparam int RANDOM_ITEMS = 425;
  localparam int MAX_GAP      = 18;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [WAIT_W-1:0]  wait_s;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } sched_result_t;

  typedef struct {
    logic [TAG_W-1:0]   tag;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic               last;
    bit                 typed;
    sched_result_t      want;
  } stim_row_t;

  typedef enum int {ARR_SPREAD, ARR_CLUSTER, ARR_TIES, ARR_BACK_TO_BACK} arr_pattern_e;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [TAG_W-1:0]   proc_tag_i;
  logic [ARR_W-1:0]   arrival_time_i;
  logic [BURST_W-1:0] burst_time_i;
  logic               last_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [TAG_W-1:0]   out_tag_o;
  logic [ARR_W-1:0]   out_arrival_o;
  logic [BURST_W-1:0] out_burst_o;
  logic [WAIT_W-1:0]  wait_time_o;
  logic [TOTAL_W-1:0] total_wait_o;
  logic               last_result_o;

  rec_t          loaded_recs[$];
  sched_result_t sched_expected[$];
  stim_row_t     stim_rows[$];
  int            error_count = 0;
  bit            in_calm = 0;
  bit            out_calm = 0;

  fcfs_waiting_time_scheduler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .proc_tag_i     (proc_tag_i),
    .arrival_time_i (arrival_time_i),
    .burst_time_i   (burst_time_i),
    .last_item_i    (last_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_tag_o      (out_tag_o),
    .out_arrival_o  (out_arrival_o),
    .out_burst_o    (out_burst_o),
    .wait_time_o    (wait_time_o),
    .total_wait_o   (total_wait_o),
    .last_result_o  (last_result_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) begin
      report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  // stable sort by arrival, then serve in order
  function automatic void schedule_set(ref sched_result_t res[$]);
    rec_t          srt[$];
    rec_t          key;
    int            j;
    longint        exit_s;
    longint        wait_s;
    longint        total;
    sched_result_t r;
    srt = loaded_recs;
    for (int i = 1; i < srt.size(); i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1].arr > key.arr) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    exit_s = 0;
    total = 0;
    for (int i = 0; i < srt.size(); i++) begin
      wait_s = (i > 0 && exit_s > srt[i].arr) ? exit_s - srt[i].arr : 0;
      exit_s = srt[i].arr + wait_s + srt[i].burst;
      total += wait_s;
      r.tag    = srt[i].tag;
      r.arr    = srt[i].arr;
      r.burst  = srt[i].burst;
      r.wait_s = (wait_s > WAIT_MAX) ? WAIT_MAX : wait_s[WAIT_W-1:0];
      r.total  = (total > TOTAL_MAX) ? TOTAL_MAX : total[TOTAL_W-1:0];
      r.last   = (i == srt.size() - 1);
      res.push_back(r);
    end
  endfunction

  task automatic take_request(stim_row_t row);
    sched_result_t batch[$];
    rec_t          rec;
    rec.tag   = row.tag;
    rec.arr   = row.arr;
    rec.burst = row.burst;
    // records beyond capacity are dropped, but the last mark still closes the set
    if (loaded_recs.size() < MAX_PROCS) loaded_recs.push_back(rec);
    if (row.last) begin
      schedule_set(batch);
      loaded_recs.delete();
      if (row.typed) begin
        sched_expected.push_back(row.want);
      end else begin
        foreach (batch[i]) sched_expected.push_back(batch[i]);
      end
    end
  endtask

  function automatic void add_row(int tag, int arr, int burst, int last,
                                  int typed = 0, sched_result_t want = '0);
    stim_row_t row;
    row.tag   = TAG_W'(tag);
    row.arr   = ARR_W'(arr);
    row.burst = BURST_W'(burst);
    row.last  = (last != 0);
    row.typed = (typed != 0);
    row.want  = want;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_directed();
    // lone record at the low extremes
    add_row(0, 0, 0, 1, 1, '{tag: 0, arr: 0, burst: 0, wait_s: 0, total: 0, last: 1});
    // lone record at the highest tag and burst, arriving at ARR_TOP
    add_row(15, ARR_TOP, 65535, 1, 1,
            '{tag: 15, arr: ARR_TOP, burst: 65535, wait_s: 0, total: 0, last: 1});
    // loaded out of order with an arrival tie
    add_row(1, 100, 50, 0);
    add_row(2, 20, 30, 0);
    add_row(3, 20, 10, 1);
    // second process arrives exactly at the first one's exit
    add_row(4, 10, 5, 0);
    add_row(5, 15, 7, 1);
    // overfull set, all at time zero with the longest bursts; closing request is dropped
    for (int i = 0; i < MAX_PROCS + 2; i++) begin
      add_row(i % 16, 0, 65535, i == MAX_PROCS + 1);
    end
  endfunction

  function automatic void add_random_set();
    int           n;
    int           base;
    int           chain;
    int           arr;
    int           burst;
    arr_pattern_e pat;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4)
                                    : $urandom_range(1, MAX_PROCS);
    pat = arr_pattern_e'($urandom_range(0, 3));
    base = $urandom_range(0, ARR_TOP);
    chain = base;
    for (int i = 0; i < n; i++) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 300);
      case (pat)
        ARR_SPREAD:  arr = $urandom_range(0, ARR_TOP);
        ARR_CLUSTER: arr = base + $urandom_range(0, 400);
        ARR_TIES:    arr = base + 50 * $urandom_range(0, 3);
        default: begin
          // each process arrives as the previous one leaves
          arr = chain;
          chain = chain + burst;
        end
      endcase
      if (arr > ARR_TOP) arr = ARR_TOP;
      add_row($urandom_range(0, 15), arr, burst, i == n - 1);
    end
  endfunction

  // occasional runs with no idle cycles at all
  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // request side
  initial begin
    int gap;
    int directed_rows;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    proc_tag_i     = '0;
    arrival_time_i = '0;
    burst_time_i   = '0;
    last_item_i    = 1'b0;
    out_ready_i    = 1'b0;
    add_directed();
    directed_rows = stim_rows.size();
    while (stim_rows.size() < directed_rows + RANDOM_ITEMS) add_random_set();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (stim_rows[k]) begin
      gap = draw_gap(in_calm);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_valid_i     <= 1'b1;
      proc_tag_i     <= stim_rows[k].tag;
      arrival_time_i <= stim_rows[k].arr;
      burst_time_i   <= stim_rows[k].burst;
      last_item_i    <= stim_rows[k].last;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      take_request(stim_rows[k]);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
    while (sched_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    sched_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sched_expected.size() == 0) begin
        report_error($sformatf("unexpected result, tag %0d", out_tag_o));
      end else begin
        want = sched_expected.pop_front();
        check_field("out_tag", out_tag_o, want.tag);
        check_field("out_arrival", out_arrival_o, want.arr);
        check_field("out_burst", out_burst_o, want.burst);
        check_field("wait_time", wait_time_o, want.wait_s);
        check_field("total_wait", total_wait_o, want.total);
        check_field("last_result", last_result_o, want.last);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
